FILE: src/tgad_pkg.sv
// Shared types, constants and decode helpers for the TGA pixel stream decoder.
// Used by tgad_palette and tga_pixel_stream_decoder; depends on nothing else.

package tgad_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam logic [8:0] PAL_LIMIT = 9'(PAL_ENTRIES);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 15;
  localparam int DIM_W = 15;
  localparam int PIX_CNT_W = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_KIND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;

  localparam logic [1:0] KIND_CMAP = 2'd0;
  localparam logic [1:0] KIND_TRUE = 2'd1;
  localparam logic [1:0] KIND_GRAY = 2'd2;

  localparam logic [1:0] DEPTH_8 = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  localparam logic [7:0] HDR_LEN_MASK = 8'h7F;
  localparam logic [7:0] HDR_REPEAT = 8'h80;
  localparam logic [15:0] RGB555_RED = 16'h7C00;
  localparam logic [15:0] RGB555_GREEN = 16'h03E0;
  localparam logic [15:0] RGB555_BLUE = 16'h001F;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  entry_index;
    logic [23:0] entry_color;
    logic [7:0]  data_byte;
  } tgad_in_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] gray;
    logic [7:0]  run_length;
    logic        image_done;
  } tgad_out_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  waddr;
    logic [23:0] wdata;
    logic        re;
    logic [7:0]  raddr;
  } tgad_pal_req_t;

  // Byte index of the last byte of a pixel (bytes per pixel minus one).
  function automatic logic [1:0] last_phase(input logic [1:0] kind, input logic [1:0] depth);
    logic [1:0] lp;
    unique case (kind)
      KIND_CMAP: lp = 2'd0;
      KIND_GRAY: lp = (depth == DEPTH_8) ? 2'd0 : 2'd1;
      default: begin
        unique case (depth)
          DEPTH_16: lp = 2'd1;
          DEPTH_24: lp = 2'd2;
          default:  lp = 2'd3;
        endcase
      end
    endcase
    return lp;
  endfunction

endpackage

FILE: src/tgad_palette.sv
// Palette store: 24-bit BGR entries in a synchronous memory with one read port.
// Depends on tgad_pkg for the depth and the request struct.

module tgad_palette import tgad_pkg::*; (
  input  logic          clk,
  input  tgad_pal_req_t req,
  output logic [23:0]   rd_data
);

  logic [23:0] mem_r [PAL_ENTRIES];
  logic [23:0] rd_r;
  logic        rd_hit_r;

  always_ff @(posedge clk) begin
    if (req.we && ({1'b0, req.waddr} < PAL_LIMIT)) begin
      mem_r[req.waddr[PAL_AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rd_r <= mem_r[req.raddr[PAL_AW-1:0]];
      rd_hit_r <= ({1'b0, req.raddr} < PAL_LIMIT);
    end
  end

  assign rd_data = rd_hit_r ? rd_r : 24'd0;

endmodule

FILE: src/tga_pixel_stream_decoder.sv
// Top level of the TGA pixel stream decoder: packet parsing, pixel assembly and output stage.
// Depends on tgad_pkg and tgad_palette.
//
// Each input request is either a palette entry write (cmd 0) or one byte of pixel data
// (cmd 1). The decoder parses RLE packet headers, gathers the bytes of a pixel and emits
// one result per completed pixel: RGBA or gray with a run length, so a repeat packet
// gives a single result. The last pixel of the image sets image_done and re-arms the
// decoder for the next image.
// One request is accepted per cycle, back to back, while in_ready is high. A pixel completed
// by the byte taken at an edge reads the palette memory at that edge into the palette read
// stage and then moves into the output register, which drives out_valid, once that register
// is free or out_ready is high. The palette read is the only extra stage; headers, palette
// writes and leading pixel bytes give no result.
// When the receiver stalls, one result waits in the output register and one more in the
// palette read stage; in_ready then drops until the output register drains.
// Configuration writes to indices up to CFG_HEIGHT take effect at once and restart the
// decoder; the palette keeps its contents. Reset is synchronous and restores the default
// format (truecolor, 24 bit, raw, 1 by 1 image); palette entries are undefined until written.

module tga_pixel_stream_decoder import tgad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tgad_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tgad_out_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [1:0]           kind_r, kind_nxt;
  logic                 rle_r, rle_nxt;
  logic [1:0]           depth_r, depth_nxt;
  logic [DIM_W-1:0]     width_r, width_nxt;
  logic [DIM_W-1:0]     height_r, height_nxt;
  logic [PIX_CNT_W-1:0] total_r, total_nxt;
  logic                 fresh_r, fresh_nxt;
  logic                 expect_r, expect_nxt;
  logic                 repeat_r, repeat_nxt;
  logic [7:0]           pkt_left_r, pkt_left_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [23:0]          partial_r, partial_nxt;
  logic [PIX_CNT_W-1:0] pixels_left_r, pixels_left_nxt;

  logic                 s1_v_r;
  logic [31:0]          s1_px_r;
  logic [7:0]           s1_run_r;
  logic                 s1_done_r;
  logic                 out_v_r;
  tgad_out_t            out_data_r;

  logic                 in_fire, pix, hdr, mid, emit, out_adv;
  logic [1:0]           lp;
  logic [31:0]          px;
  logic [7:0]           b, run_raw, run, pkt_after;
  logic [PIX_CNT_W-1:0] pl_eff, pl_next;
  logic                 done;
  logic [DIM_W-1:0]     cfg_dim, mul_a, mul_b;
  tgad_pal_req_t        pal_req;
  logic [23:0]          pal_rd;
  tgad_out_t            fmt;

  assign out_adv  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || out_adv;
  assign in_fire  = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign lp       = last_phase(kind_r, depth_r);
  assign pix      = in_fire && (in_data.cmd == CMD_DATA);
  assign hdr      = pix && rle_r && expect_r;
  assign mid      = pix && !hdr && (phase_r < lp);
  assign emit     = pix && !hdr && !mid;
  assign pl_eff   = fresh_r ? total_r : pixels_left_r;

  always_comb begin
    px = {8'd0, partial_r};
    case (phase_r)
      2'd0:    px[7:0]   = px[7:0] | b;
      2'd1:    px[15:8]  = px[15:8] | b;
      2'd2:    px[23:16] = px[23:16] | b;
      default: px[31:24] = b;
    endcase
  end

  always_comb begin
    run_raw = 8'd1;
    pkt_after = pkt_left_r;
    if (rle_r) begin
      if (repeat_r) begin
        run_raw = pkt_left_r;
        pkt_after = 8'd0;
      end else begin
        pkt_after = (pkt_left_r != 8'd0) ? pkt_left_r - 8'd1 : 8'd0;
      end
    end
    if (run_raw == 8'd0) begin
      run_raw = 8'd1;
    end
    run = ({{(PIX_CNT_W-8){1'b0}}, run_raw} > pl_eff) ? pl_eff[7:0] : run_raw;
    pl_next = pl_eff - {{(PIX_CNT_W-8){1'b0}}, run};
    done = (pl_next == '0);
  end

  assign cfg_dim = (cfg_data == '0) ? DIM_W'(1) : cfg_data;
  assign mul_a   = (cfg_index == CFG_WIDTH) ? cfg_dim : width_r;
  assign mul_b   = (cfg_index == CFG_HEIGHT) ? cfg_dim : height_r;

  always_comb begin
    kind_nxt = kind_r;
    rle_nxt = rle_r;
    depth_nxt = depth_r;
    width_nxt = width_r;
    height_nxt = height_r;
    total_nxt = total_r;
    fresh_nxt = fresh_r;
    expect_nxt = expect_r;
    repeat_nxt = repeat_r;
    pkt_left_nxt = pkt_left_r;
    phase_nxt = phase_r;
    partial_nxt = partial_r;
    pixels_left_nxt = pixels_left_r;
    if (cfg_wr_en) begin
      if (cfg_index <= CFG_HEIGHT) begin
        unique case (cfg_index)
          CFG_IMAGE_KIND: kind_nxt = cfg_data[1:0];
          CFG_RLE:        rle_nxt = cfg_data[0];
          CFG_DEPTH:      depth_nxt = cfg_data[1:0];
          CFG_WIDTH:      width_nxt = cfg_dim;
          default:        height_nxt = cfg_dim;
        endcase
        total_nxt = PIX_CNT_W'(mul_a) * PIX_CNT_W'(mul_b);
        fresh_nxt = 1'b1;
        expect_nxt = 1'b1;
        repeat_nxt = 1'b0;
        pkt_left_nxt = 8'd0;
        phase_nxt = 2'd0;
        partial_nxt = 24'd0;
      end
    end else if (hdr) begin
      repeat_nxt = (b & HDR_REPEAT) != 8'd0;
      pkt_left_nxt = (b & HDR_LEN_MASK) + 8'd1;
      expect_nxt = 1'b0;
      phase_nxt = 2'd0;
      partial_nxt = 24'd0;
    end else if (mid) begin
      case (phase_r)
        2'd0:    partial_nxt[7:0] = b;
        2'd1:    partial_nxt[15:8] = b;
        default: partial_nxt[23:16] = b;
      endcase
      phase_nxt = phase_r + 2'd1;
    end else if (emit) begin
      phase_nxt = 2'd0;
      partial_nxt = 24'd0;
      if (rle_r) begin
        pkt_left_nxt = pkt_after;
        if (pkt_after == 8'd0) begin
          expect_nxt = 1'b1;
        end
      end
      pixels_left_nxt = pl_next;
      fresh_nxt = 1'b0;
      if (done) begin
        fresh_nxt = 1'b1;
        expect_nxt = 1'b1;
        repeat_nxt = 1'b0;
        pkt_left_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_TRUE;
      rle_r <= 1'b0;
      depth_r <= DEPTH_24;
      width_r <= DIM_W'(1);
      height_r <= DIM_W'(1);
      total_r <= PIX_CNT_W'(1);
      fresh_r <= 1'b1;
      expect_r <= 1'b1;
      repeat_r <= 1'b0;
      pkt_left_r <= 8'd0;
      phase_r <= 2'd0;
      partial_r <= 24'd0;
      pixels_left_r <= PIX_CNT_W'(1);
      s1_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      kind_r <= kind_nxt;
      rle_r <= rle_nxt;
      depth_r <= depth_nxt;
      width_r <= width_nxt;
      height_r <= height_nxt;
      total_r <= total_nxt;
      fresh_r <= fresh_nxt;
      expect_r <= expect_nxt;
      repeat_r <= repeat_nxt;
      pkt_left_r <= pkt_left_nxt;
      phase_r <= phase_nxt;
      partial_r <= partial_nxt;
      pixels_left_r <= pixels_left_nxt;
      if (in_ready) begin
        s1_v_r <= emit;
      end
      if (out_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_px_r <= px;
      s1_run_r <= run;
      s1_done_r <= done;
    end
    if (out_adv) begin
      out_data_r <= fmt;
    end
  end

  assign pal_req.we    = in_fire && (in_data.cmd == CMD_PALETTE);
  assign pal_req.waddr = in_data.entry_index;
  assign pal_req.wdata = in_data.entry_color;
  assign pal_req.re    = emit;
  assign pal_req.raddr = px[7:0];

  tgad_palette u_palette (
    .clk     (clk),
    .req     (pal_req),
    .rd_data (pal_rd)
  );

  always_comb begin
    fmt = '0;
    fmt.alpha = ALPHA_OPAQUE;
    fmt.run_length = s1_run_r;
    fmt.image_done = s1_done_r;
    unique case (kind_r)
      KIND_CMAP: begin
        fmt.blue = pal_rd[7:0];
        fmt.green = pal_rd[15:8];
        fmt.red = pal_rd[23:16];
      end
      KIND_GRAY: begin
        fmt.gray = (lp == 2'd0) ? {8'd0, s1_px_r[7:0]} : s1_px_r[15:0];
      end
      default: begin
        if (lp == 2'd1) begin
          fmt.red = {s1_px_r[14:10], 3'b000};
          fmt.green = {s1_px_r[9:5], 3'b000};
          fmt.blue = {s1_px_r[4:0], 3'b000};
        end else begin
          fmt.blue = s1_px_r[7:0];
          fmt.green = s1_px_r[15:8];
          fmt.red = s1_px_r[23:16];
          if (lp == 2'd3) begin
            fmt.alpha = s1_px_r[31:24];
          end
        end
      end
    endcase
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.run_length != 8'd0)
    else $error("result with zero run length");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    !fresh_r |-> pixels_left_r != '0)
    else $error("pixel count reached zero without restart");

  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= lp)
    else $error("byte phase beyond pixel size");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_adv |=> s1_v_r && $stable(s1_px_r) && $stable(s1_run_r))
    else $error("palette stage lost a pending pixel");

endmodule
